/* design/wav_pkg.sv */
// ----------------------------------------------------------------------------
// wav_pkg: shared types and codes for the WAV stream parser
// Output word layout, word kinds, error codes and RIFF chunk tags.
// ----------------------------------------------------------------------------
package wav_pkg;

  // word kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_RIFF_WAVE = 4'd1;
  localparam logic [3:0] ERR_NO_FMT    = 4'd2;
  localparam logic [3:0] ERR_NOT_PCM   = 4'd3;
  localparam logic [3:0] ERR_BITS      = 4'd4;
  localparam logic [3:0] ERR_NO_DATA   = 4'd5;
  localparam logic [3:0] ERR_CHANNELS  = 4'd6;
  localparam logic [3:0] ERR_ZERO_SMP  = 4'd7;
  localparam logic [3:0] ERR_TRUNC     = 4'd8;

  // big-endian ASCII tags as they shift in
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] sample_value;
    logic [1:0]         channel_count;
    logic [31:0]        sample_rate;
    logic [4:0]         sample_bits;
    logic [30:0]        data_length;
    logic [3:0]         error_code;
    logic               last;
  } item_t;

endpackage

/* design/wav_riff_stream_parser.sv */
// ----------------------------------------------------------------------------
// wav_riff_stream_parser: RIFF/WAVE header parser and PCM sample unpacker
// Walks the chunk list of a WAV file one byte at a time, reports the fmt
// values once the data chunk is found, then emits the PCM samples.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: one file byte per word (data_byte), with first_byte to
//   restart on a new file and end_of_file on the final byte. A word is taken
//   when in_valid is high and in_stall is low.
//   Output channel: header, sample and error words, each field on its own
//   port, taken when out_valid is high and out_stall is low.
//   Path: an accepted byte is held in the input register and parsed from
//   there; its words are written to the queue when the parser advances,
//   and out_valid rises once the queue holds a word.
//   Throughput: one byte per cycle. A byte gives at most two words (header
//   or sample plus a truncation error); the four-entry output queue takes
//   the next byte whenever at most two entries are held, so a receiver that
//   takes a word every cycle never slows the byte stream.
//   Stall: when the receiver stalls, the queue fills and then in_stall rises
//   and holds the pending byte; nothing is dropped.
//   Reset: rst clears the queue and the input register and puts the parser
//   back at the RIFF tag. first_byte does the same for the parse state of
//   the byte that carries it.
//   After an error or the final sample, bytes are consumed silently until the
//   next first_byte.
// ----------------------------------------------------------------------------
module wav_riff_stream_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               first_byte,
  input  logic               end_of_file,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic signed [15:0] sample_value,
  output logic [1:0]         channel_count,
  output logic [31:0]        sample_rate,
  output logic [4:0]         sample_bits,
  output logic [30:0]        data_length,
  output logic [3:0]         error_code,
  output logic               last
);
  import wav_pkg::*;

  // parse phases
  localparam logic [3:0] PH_RIFF      = 4'd0;
  localparam logic [3:0] PH_FMT_HDR   = 4'd1;
  localparam logic [3:0] PH_FMT_SKIP  = 4'd2;
  localparam logic [3:0] PH_FMT_BODY  = 4'd3;
  localparam logic [3:0] PH_FMT_EXTRA = 4'd4;
  localparam logic [3:0] PH_DATA_HDR  = 4'd5;
  localparam logic [3:0] PH_DATA_SKIP = 4'd6;
  localparam logic [3:0] PH_SAMPLES   = 4'd7;
  localparam logic [3:0] PH_IDLE      = 4'd8;

  localparam int QDEPTH = 4;

  // OR a byte into one of the four byte lanes of a word
  function automatic logic [31:0] put_lane(input logic [31:0] w, input logic [7:0] b,
                                           input logic [1:0] lane);
    put_lane = w | ({24'd0, b} << {lane, 3'b000});
  endfunction

  // ---------------------------------------------------------------- input reg
  logic       r_valid;
  logic [7:0] r_byte;
  logic       r_first;
  logic       r_eof;
  logic       adv;

  // ---------------------------------------------------------------- state
  logic [3:0]  phase, phase_next;
  logic [4:0]  byte_count, byte_count_next;
  logic [31:0] field_shift, field_shift_next;
  logic [31:0] chunk_tag, chunk_tag_next;
  logic [1:0]  held_channels, held_channels_next;
  logic [31:0] held_rate, held_rate_next;
  logic [4:0]  held_bits, held_bits_next;
  logic [30:0] data_remaining, data_remaining_next;
  logic [7:0]  low_sample_byte, low_sample_byte_next;

  // ---------------------------------------------------------------- queue
  item_t       queue [QDEPTH];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  count;
  logic        pop;

  // ---------------------------------------------------------------- parse
  logic [3:0]  cur_phase;
  logic [4:0]  cur_bc, bc_inc;
  logic [31:0] cur_fs, cur_tag, pad;
  logic [30:0] dr_dec;
  logic [2:0]  min_len;
  logic        is_fmt, hdr_push, smp_push, err_hit, eof_err, no_step;
  logic [15:0] smp_val;
  logic        smp_last;
  logic [3:0]  err_code, eof_code;
  item_t       item0, item1;
  logic [1:0]  n_push;

  assign adv      = r_valid && (count <= 3'(QDEPTH - 2));
  assign in_stall = r_valid && !adv;
  assign pop      = out_valid && !out_stall;

  always_comb begin
    // first_byte restarts from the reset parse state
    cur_phase = r_first ? PH_RIFF : phase;
    cur_bc    = r_first ? 5'd0 : byte_count;
    cur_fs    = r_first ? 32'd0 : field_shift;
    cur_tag   = r_first ? 32'd0 : chunk_tag;

    phase_next           = cur_phase;
    byte_count_next      = cur_bc;
    field_shift_next     = cur_fs;
    chunk_tag_next       = cur_tag;
    held_channels_next   = held_channels;
    held_rate_next       = held_rate;
    held_bits_next       = held_bits;
    data_remaining_next  = data_remaining;
    low_sample_byte_next = low_sample_byte;

    bc_inc   = cur_bc + 5'd1;
    is_fmt   = (cur_phase == PH_FMT_HDR);
    pad      = 32'd0;
    dr_dec   = data_remaining - 31'd1;
    min_len  = (held_channels == 2'd2) ? {held_bits[4:3], 1'b0} : {1'b0, held_bits[4:3]};
    hdr_push = 1'b0;
    smp_push = 1'b0;
    smp_val  = 16'd0;
    smp_last = 1'b0;
    err_hit  = 1'b0;
    err_code = ERR_NONE;
    no_step  = 1'b0;

    case (cur_phase)
      PH_RIFF: begin
        if (cur_bc < 5'd4 || cur_bc >= 5'd8) begin
          chunk_tag_next = {cur_tag[23:0], r_byte};
        end
        byte_count_next = bc_inc;
        if (bc_inc == 5'd4) begin
          if (chunk_tag_next != TAG_RIFF) begin
            err_hit  = 1'b1;
            err_code = ERR_RIFF_WAVE;
          end else begin
            chunk_tag_next = 32'd0;
          end
        end else if (bc_inc == 5'd12) begin
          if (chunk_tag_next != TAG_WAVE) begin
            err_hit  = 1'b1;
            err_code = ERR_RIFF_WAVE;
          end else begin
            phase_next       = PH_FMT_HDR;
            byte_count_next  = 5'd0;
            chunk_tag_next   = 32'd0;
            field_shift_next = 32'd0;
          end
        end
      end
      PH_FMT_HDR, PH_DATA_HDR: begin
        if (cur_bc < 5'd4) begin
          chunk_tag_next = {cur_tag[23:0], r_byte};
        end else begin
          field_shift_next = put_lane(cur_fs, r_byte, cur_bc[1:0]);
        end
        byte_count_next = bc_inc;
        if (bc_inc == 5'd8) begin
          pad = (field_shift_next + 32'd1) & ~32'd1;
          if (field_shift_next[31]) begin
            // negative chunk length
            err_hit  = 1'b1;
            err_code = is_fmt ? ERR_NO_FMT : ERR_NO_DATA;
          end else if (chunk_tag_next == (is_fmt ? TAG_FMT : TAG_DATA)) begin
            data_remaining_next = field_shift_next[30:0];
            byte_count_next     = 5'd0;
            field_shift_next    = 32'd0;
            if (is_fmt) begin
              phase_next     = PH_FMT_BODY;
              held_rate_next = 32'd0;
            end else if (held_channels != 2'd1 && held_channels != 2'd2) begin
              err_hit  = 1'b1;
              err_code = ERR_CHANNELS;
            end else if (data_remaining_next < {28'd0, min_len}) begin
              err_hit  = 1'b1;
              err_code = ERR_ZERO_SMP;
            end else begin
              hdr_push   = 1'b1;
              phase_next = PH_SAMPLES;
            end
          end else if (pad == 32'd0) begin
            byte_count_next  = 5'd0;
            chunk_tag_next   = 32'd0;
            field_shift_next = 32'd0;
          end else begin
            phase_next       = is_fmt ? PH_FMT_SKIP : PH_DATA_SKIP;
            field_shift_next = pad;
          end
        end
      end
      PH_FMT_SKIP, PH_DATA_SKIP, PH_FMT_EXTRA: begin
        field_shift_next = cur_fs - 32'd1;
        if (field_shift_next == 32'd0) begin
          phase_next      = (cur_phase == PH_FMT_SKIP) ? PH_FMT_HDR : PH_DATA_HDR;
          byte_count_next = 5'd0;
          chunk_tag_next  = 32'd0;
        end
      end
      PH_FMT_BODY: begin
        // format, channels and bits are 16-bit words in field_shift,
        // the rate goes straight into its holding register
        if (cur_bc < 5'd4 || cur_bc >= 5'd14) begin
          field_shift_next = put_lane(cur_fs, r_byte, {1'b0, cur_bc[0]});
        end else if (cur_bc < 5'd8) begin
          held_rate_next = put_lane(held_rate, r_byte, cur_bc[1:0]);
        end
        byte_count_next = bc_inc;
        if (cur_bc == 5'd1) begin
          if (field_shift_next != 32'd1) begin
            err_hit  = 1'b1;
            err_code = ERR_NOT_PCM;
          end else begin
            field_shift_next = 32'd0;
          end
        end else if (cur_bc == 5'd3) begin
          held_channels_next = (field_shift_next == 32'd1 || field_shift_next == 32'd2) ?
                               field_shift_next[1:0] : 2'd0;
          field_shift_next   = 32'd0;
        end else if (cur_bc == 5'd15) begin
          if (field_shift_next != 32'd8 && field_shift_next != 32'd16) begin
            err_hit  = 1'b1;
            err_code = ERR_BITS;
          end else begin
            held_bits_next = field_shift_next[4:0];
            if (data_remaining > 31'd16) begin
              phase_next       = PH_FMT_EXTRA;
              field_shift_next = {1'b0, data_remaining} - 32'd16;
              byte_count_next  = 5'd0;
            end else begin
              phase_next       = PH_DATA_HDR;
              byte_count_next  = 5'd0;
              chunk_tag_next   = 32'd0;
              field_shift_next = 32'd0;
            end
          end
        end
      end
      PH_SAMPLES: begin
        if (held_bits == 5'd8) begin
          data_remaining_next = dr_dec;
          smp_push = 1'b1;
          smp_val  = {8'd0, r_byte};
          smp_last = (dr_dec == 31'd0);
        end else if (cur_bc == 5'd0) begin
          if (data_remaining == 31'd1) begin
            // trailing odd byte is dropped
            data_remaining_next = 31'd0;
          end else begin
            low_sample_byte_next = r_byte;
            byte_count_next      = 5'd1;
            data_remaining_next  = dr_dec;
          end
        end else begin
          data_remaining_next = dr_dec;
          byte_count_next     = 5'd0;
          smp_push = 1'b1;
          smp_val  = {r_byte, low_sample_byte};
          smp_last = (dr_dec <= 31'd1);
        end
        if (data_remaining_next == 31'd0) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        no_step = 1'b1;
      end
    endcase

    if (err_hit) begin
      phase_next = PH_IDLE;
    end

    // truncation at end of file
    case (phase_next)
      PH_RIFF:                  eof_code = ERR_RIFF_WAVE;
      PH_FMT_HDR, PH_FMT_SKIP:  eof_code = ERR_NO_FMT;
      PH_FMT_BODY:              eof_code = (byte_count_next < 5'd2) ? ERR_NOT_PCM : ERR_TRUNC;
      PH_SAMPLES:               eof_code = ERR_TRUNC;
      default:                  eof_code = ERR_NO_DATA;
    endcase
    eof_err = r_eof && !err_hit && !no_step && (phase_next != PH_IDLE);
    if (eof_err) begin
      phase_next = PH_IDLE;
      err_code   = eof_code;
    end

    item0 = '0;
    item1 = '0;
    item1.kind       = KIND_ERROR;
    item1.error_code = err_code;
    item1.last       = 1'b1;
    if (hdr_push) begin
      item0.kind          = KIND_HEADER;
      item0.channel_count = held_channels;
      item0.sample_rate   = held_rate;
      item0.sample_bits   = held_bits;
      item0.data_length   = data_remaining_next;
    end else if (smp_push) begin
      item0.kind         = KIND_SAMPLE;
      item0.sample_value = smp_val;
      item0.last         = smp_last;
    end else begin
      item0 = item1;
    end
    n_push = 2'({1'b0, hdr_push | smp_push} + {1'b0, err_hit | eof_err});
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (!in_stall) begin
      r_valid <= in_valid;
    end
    if (!in_stall) begin
      r_byte  <= data_byte;
      r_first <= first_byte;
      r_eof   <= end_of_file;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_RIFF;
      byte_count      <= 5'd0;
      field_shift     <= 32'd0;
      chunk_tag       <= 32'd0;
      held_channels   <= 2'd0;
      held_rate       <= 32'd0;
      held_bits       <= 5'd0;
      data_remaining  <= 31'd0;
      low_sample_byte <= 8'd0;
    end else if (adv) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      field_shift     <= field_shift_next;
      chunk_tag       <= chunk_tag_next;
      held_channels   <= held_channels_next;
      held_rate       <= held_rate_next;
      held_bits       <= held_bits_next;
      data_remaining  <= data_remaining_next;
      low_sample_byte <= low_sample_byte_next;
    end
  end

  // output queue: up to two words in, one out per cycle while out_stall is low
  always_ff @(posedge clk) begin
    if (adv && n_push != 2'd0) begin
      queue[wr_ptr] <= item0;
    end
    if (adv && n_push == 2'd2) begin
      queue[wr_ptr + 2'd1] <= item1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (adv) begin
        wr_ptr <= wr_ptr + n_push;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + (adv ? {1'b0, n_push} : 3'd0) - {2'd0, pop};
    end
  end

  assign out_valid     = (count != 3'd0);
  assign kind          = queue[rd_ptr].kind;
  assign sample_value  = queue[rd_ptr].sample_value;
  assign channel_count = queue[rd_ptr].channel_count;
  assign sample_rate   = queue[rd_ptr].sample_rate;
  assign sample_bits   = queue[rd_ptr].sample_bits;
  assign data_length   = queue[rd_ptr].data_length;
  assign error_code    = queue[rd_ptr].error_code;
  assign last          = queue[rd_ptr].last;

endmodule

/* design/wav_checker.sv */
// ----------------------------------------------------------------------------
// wav_checker: port-level checks for the WAV stream parser
// Watches the output channel for word-shape and handshake slips.
// ----------------------------------------------------------------------------
module wav_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         kind,
  input logic signed [15:0] sample_value,
  input logic [1:0]         channel_count,
  input logic [4:0]         sample_bits,
  input logic [3:0]         error_code,
  input logic               last
);
  import wav_pkg::*;

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(sample_value)
      && $stable(error_code) && $stable(last))
    else $error("stalled output word changed");

  // error words always end the stream
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ERROR |-> last && error_code != ERR_NONE)
    else $error("error word without last or code");

  // header words carry checked format values
  a_header_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_HEADER |-> !last
      && (channel_count == 2'd1 || channel_count == 2'd2)
      && (sample_bits == 5'd8 || sample_bits == 5'd16))
    else $error("malformed header word");
endmodule

bind wav_riff_stream_parser wav_checker u_wav_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .kind          (kind),
  .sample_value  (sample_value),
  .channel_count (channel_count),
  .sample_bits   (sample_bits),
  .error_code    (error_code),
  .last          (last)
);
